// ----- sv/elevator_disk_request_scheduler_assert.svh -----
// Assertion macros shared by the checker of the elevator request scheduler.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ELEVATOR_DISK_REQUEST_SCHEDULER_ASSERT_SVH
`define ELEVATOR_DISK_REQUEST_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define EDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Implication in the next cycle.
`define EDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ----- sv/eds_pkg.sv -----
// Shared types and constants of the elevator request scheduler.
// No dependencies; used by every RTL file of the block.
package eds_pkg;

  localparam int MAX_REQUESTS_DEF = 64;
  localparam int TRACK_BITS_DEF   = 10;

  // Configuration port.
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int TOTAL_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_TRACK = 1'b0,
    CFG_START_DIR   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK
  } state_t;

  // Control of the shared compare unit.
  typedef struct packed {
    logic clear;   // drop the current best candidate
    logic en;      // a stored request is presented this cycle
    logic dir;     // 1: sweep toward higher tracks
    logic served;  // the presented request was already served
  } cmp_ctrl_t;

endpackage

// ----- sv/eds_cmp.sv -----
// Shared compare unit: keeps the nearest unserved request ahead of the head.
// Depends on eds_pkg.
module eds_cmp #(
  parameter int TRACK_BITS = eds_pkg::TRACK_BITS_DEF,
  parameter int AW         = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  eds_pkg::cmp_ctrl_t    ctrl,
  input  logic [TRACK_BITS-1:0] track,
  input  logic [TRACK_BITS-1:0] head,
  input  logic [AW-1:0]         idx,
  output logic                  found,
  output logic [TRACK_BITS-1:0] best_dist,
  output logic [TRACK_BITS-1:0] best_track,
  output logic [AW-1:0]         best_idx
);
  import eds_pkg::*;

  logic                  found_r;
  logic [TRACK_BITS-1:0] dist_r;
  logic [TRACK_BITS-1:0] track_r;
  logic [AW-1:0]         idx_r;
  logic                  ahead;
  logic [TRACK_BITS-1:0] cand_dist;
  logic                  take;

  // A request at the head counts as ahead in both directions.
  always_comb begin
    ahead     = ctrl.dir ? (track >= head) : (track <= head);
    cand_dist = ctrl.dir ? (track - head) : (head - track);
    // Strict less-than keeps the earliest stored request on a tie.
    take      = ctrl.en && !ctrl.served && ahead && (!found_r || (cand_dist < dist_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctrl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dist_r  <= cand_dist;
      track_r <= track;
      idx_r   <= idx;
    end
  end

  assign found      = found_r;
  assign best_dist  = dist_r;
  assign best_track = track_r;
  assign best_idx   = idx_r;

endmodule

// ----- sv/elevator_disk_request_scheduler.sv -----
// Elevator (LOOK) disk request scheduler. Loads a batch of track requests and
// serves them in sweep order. Depends on eds_pkg and eds_cmp.
//
// A request beat without batch_end is stored and busy stays low.
// The beat with batch_end starts service: each served request takes a full
// scan, in which the request memory is read one entry per cycle into the
// shared compare unit, followed by one compare stage, the detection of the
// drained scan, and the pick state. A sweep reversal adds another full scan.
// Results appear on out_valid for a single cycle each and cannot be held off;
// busy drops in the cycle that shows the last result of a batch.
// Requests beyond MAX_REQUESTS in one batch are dropped.
module elevator_disk_request_scheduler #(
  parameter int MAX_REQUESTS = eds_pkg::MAX_REQUESTS_DEF,
  parameter int TRACK_BITS   = eds_pkg::TRACK_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [TRACK_BITS-1:0]          in_request_track,
  input  logic                           in_batch_end,
  output logic                           out_valid,
  output logic [TRACK_BITS-1:0]          out_served_track,
  output logic [TRACK_BITS-1:0]          out_seek_distance,
  output logic [eds_pkg::TOTAL_W-1:0]    out_total_seek,
  output logic                           out_order_end,
  input  logic                           cfg_we,
  input  logic [eds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eds_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import eds_pkg::*;

  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int EXT_W = 16;

  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0]   start_track_r;
  logic                    start_dir_r;

  logic [TRACK_BITS-1:0]   mem [MAX_REQUESTS];
  logic [TRACK_BITS-1:0]   rd_data_r;
  logic [MAX_REQUESTS-1:0] served_r;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           ptr_r;
  logic [CW-1:0]           done_cnt_r;
  logic                    pend_v_r;
  logic [AW-1:0]           pend_idx_r;
  logic [TRACK_BITS-1:0]   head_r;
  logic                    dir_r;
  logic                    flipped_r;
  logic [TOTAL_W-1:0]      total_r;

  logic                    out_valid_r;
  logic [TRACK_BITS-1:0]   out_track_r;
  logic [TRACK_BITS-1:0]   out_dist_r;
  logic                    out_end_r;

  logic                    accept;
  logic                    store;
  logic                    issue;
  logic                    scan_done;
  logic                    last_pick;
  cmp_ctrl_t               cmp_ctrl;
  logic                    found;
  logic [TRACK_BITS-1:0]   best_dist;
  logic [TRACK_BITS-1:0]   best_track;
  logic [AW-1:0]           best_idx;
  logic [EXT_W-1:0]        start_ext;
  logic [TOTAL_W:0]        total_sum;
  logic [TOTAL_W-1:0]      total_nxt;

  assign accept    = start && (state_r == ST_IDLE);
  assign store     = accept && (count_r < CW'(MAX_REQUESTS));
  assign scan_done = (ptr_r == count_r) && !pend_v_r;
  assign last_pick = (done_cnt_r + CW'(1)) == count_r;
  assign start_ext = EXT_W'(start_track_r);

  always_comb begin
    total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(best_dist);
    total_nxt = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_batch_end) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (found) state_nxt = last_pick ? ST_IDLE : ST_SCAN;
        else       state_nxt = flipped_r ? ST_IDLE : ST_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    busy           = (state_r != ST_IDLE);
    issue          = (state_r == ST_SCAN) && (ptr_r < count_r);
    cmp_ctrl.clear = (state_r == ST_PICK);
    cmp_ctrl.en    = pend_v_r;
    cmp_ctrl.dir   = dir_r;
    cmp_ctrl.served = served_r[pend_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_track_r <= '0;
      start_dir_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_TRACK: start_track_r <= cfg_wdata;
        CFG_START_DIR:   start_dir_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Request memory: one write port at load, one registered read during a scan.
  always_ff @(posedge clk) begin
    if (store) mem[count_r[AW-1:0]] <= in_request_track;
  end

  always_ff @(posedge clk) begin
    if (issue) rd_data_r <= mem[ptr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      served_r    <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      done_cnt_r  <= '0;
      pend_v_r    <= 1'b0;
      pend_idx_r  <= '0;
      head_r      <= '0;
      dir_r       <= 1'b1;
      flipped_r   <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      out_end_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      pend_v_r    <= issue;
      if (issue) begin
        pend_idx_r <= ptr_r[AW-1:0];
        ptr_r      <= ptr_r + CW'(1);
      end
      if (store) count_r <= count_r + CW'(1);
      if (accept && in_batch_end) begin
        head_r     <= start_ext[TRACK_BITS-1:0];
        dir_r      <= start_dir_r;
        total_r    <= '0;
        done_cnt_r <= '0;
        flipped_r  <= 1'b0;
        ptr_r      <= '0;
      end
      if (state_r == ST_PICK) begin
        ptr_r <= '0;
        if (found) begin
          out_valid_r          <= 1'b1;
          out_end_r            <= last_pick;
          head_r               <= best_track;
          total_r              <= total_nxt;
          served_r[best_idx]   <= 1'b1;
          done_cnt_r           <= done_cnt_r + CW'(1);
          flipped_r            <= 1'b0;
          if (last_pick) begin
            count_r  <= '0;
            served_r <= '0;
          end
        end else if (!flipped_r) begin
          // Nothing ahead: reverse the sweep and search again.
          dir_r     <= ~dir_r;
          flipped_r <= 1'b1;
        end else begin
          count_r   <= '0;
          served_r  <= '0;
          flipped_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_PICK) && found) begin
      out_track_r <= best_track;
      out_dist_r  <= best_dist;
    end
  end

  eds_cmp #(
    .TRACK_BITS (TRACK_BITS),
    .AW         (AW)
  ) u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (cmp_ctrl),
    .track      (rd_data_r),
    .head       (head_r),
    .idx        (pend_idx_r),
    .found      (found),
    .best_dist  (best_dist),
    .best_track (best_track),
    .best_idx   (best_idx)
  );

  assign out_valid         = out_valid_r;
  assign out_served_track  = out_track_r;
  assign out_seek_distance = out_dist_r;
  assign out_total_seek    = total_r;
  assign out_order_end     = out_end_r;

endmodule

// ----- sv/eds_checker.sv -----
// Port-level checks of the elevator request scheduler, bound to its top level.
// Depends on eds_pkg and elevator_disk_request_scheduler_assert.svh.
`include "elevator_disk_request_scheduler_assert.svh"

module eds_checker #(
  parameter int TRACK_BITS = eds_pkg::TRACK_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_batch_end,
  input logic                        out_valid,
  input logic [TRACK_BITS-1:0]       out_seek_distance,
  input logic [eds_pkg::TOTAL_W-1:0] out_total_seek,
  input logic                        out_order_end
);
  import eds_pkg::*;

  // A non-final request beat is only stored.
  `EDS_ASSERT_NEXT(a_store_only, start && !busy && !in_batch_end, !busy && !out_valid)
  // The final beat of a batch always starts service.
  `EDS_ASSERT_NEXT(a_batch_starts, start && !busy && in_batch_end, busy)
  // Each pick needs a fresh scan, so results never come in adjacent cycles.
  `EDS_ASSERT_NEXT(a_result_gap, out_valid, !out_valid)
  // More results follow only while the block is still working.
  `EDS_ASSERT_NOW(a_more_busy, out_valid && !out_order_end, busy)
  // The running total includes the current seek.
  `EDS_ASSERT_NOW(a_total_ge, out_valid, out_total_seek >= TOTAL_W'(out_seek_distance))

endmodule

bind elevator_disk_request_scheduler eds_checker #(
  .TRACK_BITS (TRACK_BITS)
) u_eds_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_batch_end      (in_batch_end),
  .out_valid         (out_valid),
  .out_seek_distance (out_seek_distance),
  .out_total_seek    (out_total_seek),
  .out_order_end     (out_order_end)
);
